// ===== design/dsswu_pkg.sv =====
package dsswu_pkg;

  // Field widths of the request and result transfers.
  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned SEG_W  = 7;
  localparam int unsigned DIG_W  = 4;

  // A 32-bit value has at most ten decimal digits.
  localparam int unsigned MAX_DIGITS = 10;

  // Default number of display positions.
  localparam int unsigned NUM_DISPLAYS_DEF = 8;

  // Reciprocal of ten: floor(v * RECIP_TEN / 2^35) equals v / 10 for any 32-bit v.
  localparam logic [VAL_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
  localparam int unsigned      RECIP_SHFT = 35;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SHOW   = 3'd0;
  localparam logic [OP_W-1:0] OP_CLOCK  = 3'd1;
  localparam logic [OP_W-1:0] OP_SINGLE = 3'd2;
  localparam logic [OP_W-1:0] OP_CLR1   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLRALL = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [SEG_W-1:0]  segments;
    logic              last;
  } res_t;

  // Request to the divide-by-ten unit.
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] value;
  } div_req_t;

  // Answer of the divide-by-ten unit.
  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quot;
    logic [DIG_W-1:0] rem;
  } div_rsp_t;

  // Segment pattern of one decimal digit, bit 0 is segment a.
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'b0111111;
      4'd1:    s = 7'b0000110;
      4'd2:    s = 7'b1011011;
      4'd3:    s = 7'b1001111;
      4'd4:    s = 7'b1100110;
      4'd5:    s = 7'b1101101;
      4'd6:    s = 7'b1111101;
      4'd7:    s = 7'b0000111;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1101111;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== design/dsswu_div10.sv =====
module dsswu_div10 import dsswu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [2*VAL_W-1:0] prod_q;
  logic [VAL_W-1:0]   val_q;
  logic               vld_q;
  logic [VAL_W-1:0]   quot;
  logic [DIG_W-1:0]   rem;
  logic               done_q;
  logic [VAL_W-1:0]   quot_q;
  logic [DIG_W-1:0]   rem_q;

  // Control: one valid bit per stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= req_i.start;
      done_q <= vld_q;
    end
  end

  // First stage: multiply by the reciprocal of ten.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= req_i.value * {{VAL_W{1'b0}}, RECIP_TEN};
      val_q  <= req_i.value;
    end
  end

  // Second stage: quotient from the high product bits, remainder from the low bits.
  // The remainder is below ten, so four bits of the difference are enough.
  assign quot = VAL_W'(prod_q >> RECIP_SHFT);
  assign rem  = val_q[DIG_W-1:0] - ((quot[DIG_W-1:0] << 3) + (quot[DIG_W-1:0] << 1));

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      quot_q <= quot;
      rem_q  <= rem;
    end
  end

  assign rsp_o = {done_q, quot_q, rem_q};

endmodule

// ===== design/dsswu_seq.sv =====
module dsswu_seq import dsswu_pkg::*; #(
  parameter int unsigned NumDisplays = NUM_DISPLAYS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  req_t     req_i,
  output div_req_t div_req_o,
  input  div_rsp_t div_rsp_i,
  output res_t     res_o,
  output logic     res_strobe_o
);

  localparam int unsigned CNT_W = $clog2(NumDisplays + 1);
  localparam int unsigned CMP_W = POS_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_q;
  logic [OP_W-1:0]  op_q;
  logic [POS_W-1:0] pos_q;
  logic [DIG_W-1:0] ndig_q;
  logic [DIG_W-1:0] digits_q [MAX_DIGITS];
  logic [POS_W-1:0] base_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] idx_q;
  logic             zero_q;
  res_t             res_q;
  logic             strobe_q;

  logic             accept;
  logic             req_pos_ok;
  logic             pos_ok;
  logic [POS_W-1:0] pos_next;
  logic             en_lo;
  logic             en_hi;
  logic [DIG_W-1:0] ndig_next;
  logic             fits;
  logic             at_last;
  logic [POS_W-1:0] slot_full;

  assign accept     = start_i && (state_q == ST_IDLE);
  assign busy_o     = (state_q != ST_IDLE);
  assign req_pos_ok = {1'b0, req_i.position} < CMP_W'(NumDisplays);
  assign pos_ok     = {1'b0, pos_q} < CMP_W'(NumDisplays);
  assign pos_next   = pos_q + POS_W'(1);

  // Clock field: each of the two writes is checked on its own.
  assign en_lo = pos_ok;
  assign en_hi = ({1'b0, pos_next} < CMP_W'(NumDisplays)) &&
                 (div_rsp_i.quot < VAL_W'(MAX_DIGITS));

  // Show number: the whole digit run must fit in the row.
  assign ndig_next = ndig_q + DIG_W'(1);
  assign fits      = ({1'b0, pos_q} + CMP_W'(ndig_next)) <= CMP_W'(NumDisplays);

  assign at_last   = (idx_q + CNT_W'(1)) == cnt_q;
  assign slot_full = base_q + POS_W'(idx_q);

  // The divider starts on a show or clock request and for each further digit.
  always_comb begin
    div_req_o.start = (accept && ((req_i.opcode == OP_SHOW) || (req_i.opcode == OP_CLOCK))) ||
                      ((state_q == ST_DIV) && div_rsp_i.done && (op_q == OP_SHOW) &&
                       (div_rsp_i.quot != '0));
    div_req_o.value = accept ? req_i.value : div_rsp_i.quot;
  end

  // Sequencer: accept, divide where needed, then write one position per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ndig_q   <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (state_q == ST_EMIT);
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            ndig_q <= '0;
            idx_q  <= '0;
            case (req_i.opcode)
              OP_SHOW, OP_CLOCK: begin
                state_q <= ST_DIV;
              end
              OP_SINGLE: begin
                if (req_pos_ok && (req_i.value < VAL_W'(MAX_DIGITS))) begin
                  cnt_q   <= CNT_W'(1);
                  state_q <= ST_EMIT;
                end
              end
              OP_CLR1: begin
                if (req_pos_ok) begin
                  cnt_q   <= CNT_W'(1);
                  state_q <= ST_EMIT;
                end
              end
              OP_CLRALL: begin
                cnt_q   <= CNT_W'(NumDisplays);
                state_q <= ST_EMIT;
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_rsp_i.done) begin
            ndig_q <= ndig_next;
            if (op_q == OP_CLOCK) begin
              cnt_q   <= CNT_W'({1'b0, en_lo} + {1'b0, en_hi});
              state_q <= (en_lo || en_hi) ? ST_EMIT : ST_IDLE;
            end else if (div_rsp_i.quot == '0) begin
              cnt_q   <= CNT_W'(ndig_next);
              state_q <= fits ? ST_EMIT : ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          idx_q <= idx_q + CNT_W'(1);
          if (at_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Request fields, digit queue and write base.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.opcode;
      pos_q  <= req_i.position;
      zero_q <= (req_i.opcode == OP_CLR1) || (req_i.opcode == OP_CLRALL);
      base_q <= (req_i.opcode == OP_CLRALL) ? '0 : req_i.position;
      digits_q[0] <= req_i.value[DIG_W-1:0];
    end else if ((state_q == ST_DIV) && div_rsp_i.done) begin
      if (op_q == OP_CLOCK) begin
        base_q      <= en_lo ? pos_q : pos_next;
        digits_q[0] <= en_lo ? div_rsp_i.rem : div_rsp_i.quot[DIG_W-1:0];
        digits_q[1] <= div_rsp_i.quot[DIG_W-1:0];
      end else begin
        digits_q[ndig_q] <= div_rsp_i.rem;
      end
    end else if (state_q == ST_EMIT) begin
      // Digits leave least significant first.
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        digits_q[i] <= digits_q[i+1];
      end
    end
  end

  // Output register: one position write per strobe.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT) begin
      res_q.slot     <= slot_full[SLOT_W-1:0];
      res_q.segments <= zero_q ? '0 : seg_of(digits_q[0]);
      res_q.last     <= at_last;
    end
  end

  assign res_o        = res_q;
  assign res_strobe_o = strobe_q;

endmodule

// ===== design/decimal_seven_segment_writer_unit.sv =====
// Decimal seven-segment writer.
//
// A request transfer (req_i: opcode, position, value) is taken at a rising
// clock edge where start is high and busy is low. Each request turns into a
// run of position writes on res_o, one per cycle, each marked by res_strobe_o
// for exactly one cycle; the final write of a request has last set. A request
// that is rejected, or whose writes are all skipped, produces no transfer.
//
// Run of a request: a shown number of n digits goes digit by digit through
// the divide-by-ten unit, each digit through its multiply and quotient
// registers, then writes n positions at one per cycle. A number too long for
// its position is still divided digit by digit but writes nothing. A clock
// field takes one division plus up to two writes. A single digit or clear-one
// takes one write; clear-all takes NumDisplays writes. Each write shows on
// the outputs in the cycle after it is produced, and the next request can be
// taken while the final write is on the outputs.
//
// The receiver cannot stall: results are never held back. Reset returns the
// sequencer to idle with no pending writes and no strobe.
module decimal_seven_segment_writer_unit import dsswu_pkg::*; #(
  parameter int unsigned NumDisplays = NUM_DISPLAYS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output res_t res_o,
  output logic res_strobe_o
);

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Sequencer with digit queue and output register.
  dsswu_seq #(
    .NumDisplays(NumDisplays)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req_i),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .res_o       (res_o),
    .res_strobe_o(res_strobe_o)
  );

  // Divide-by-ten unit, used by the show and clock operations.
  dsswu_div10 u_div10 (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

endmodule
